// ----- rtl/core/lrd_pkg.sv -----
// Shared types and constants for the lockset race detector.
// No dependencies; used by every module under rtl/core.
package lrd_pkg;

   localparam int OP_W     = 3;
   localparam int THREAD_W = 4;
   localparam int LOCK_W   = 5;
   localparam int VAR_W    = 10;
   localparam int INSTR_W  = 32;

   localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
   localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd4;

   localparam logic RACE_WR = 1'b0;
   localparam logic RACE_WW = 1'b1;

   // Lockset update request from the controller to the thread table.
   typedef struct packed {
      logic                create;
      logic                acquire;
      logic                unlock;
      logic [THREAD_W-1:0] thread;
      logic [THREAD_W-1:0] child;
      logic [LOCK_W-1:0]   lock;
   } thr_cmd_type;

endpackage

// ----- rtl/core/lrd_thread_table.sv -----
// Per-thread lockset registers: create copies, acquire sets, release clears.
// Depends on lrd_pkg.
module lrd_thread_table #(
   parameter int NUM_THREADS = 16,
   parameter int NUM_LOCKS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lrd_pkg::thr_cmd_type          cmd,
   output logic [NUM_LOCKS-1:0]          held
);
   import lrd_pkg::*;

   localparam int TIW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

   logic [NUM_LOCKS-1:0] locks_ff [NUM_THREADS];
   logic [TIW-1:0]       thr_idx;
   logic [TIW-1:0]       child_idx;
   logic [NUM_LOCKS-1:0] lock_bit;

   assign thr_idx   = TIW'(cmd.thread);
   assign child_idx = TIW'(cmd.child);
   assign lock_bit  = NUM_LOCKS'(1) << cmd.lock;
   assign held      = locks_ff[thr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            locks_ff[i] <= '0;
         end
      end else if (cmd.create) begin
         locks_ff[child_idx] <= locks_ff[thr_idx];
      end else if (cmd.acquire) begin
         locks_ff[thr_idx] <= locks_ff[thr_idx] | lock_bit;
      end else if (cmd.unlock) begin
         locks_ff[thr_idx] <= locks_ff[thr_idx] & ~lock_bit;
      end
   end

endmodule

// ----- rtl/core/lrd_var_mem.sv -----
// Per-variable store: write lockset and last write instruction in one RAM,
// swept to its reset value after reset. Depends on lrd_pkg.
module lrd_var_mem #(
   parameter int NUM_VARS  = 1024,
   parameter int NUM_LOCKS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [lrd_pkg::VAR_W-1:0]             rd_addr,
   output logic [NUM_LOCKS+lrd_pkg::INSTR_W-1:0] rd_data,
   input  logic                                  wr_en,
   input  logic [lrd_pkg::VAR_W-1:0]             wr_addr,
   input  logic [NUM_LOCKS+lrd_pkg::INSTR_W-1:0] wr_data,
   output logic                                  clearing
);
   import lrd_pkg::*;

   localparam int VIW = $clog2(NUM_VARS);
   localparam int DW  = NUM_LOCKS + INSTR_W;

   logic [DW-1:0]  mem_ff [NUM_VARS];
   logic [DW-1:0]  rd_data_ff;
   logic [VIW-1:0] clr_idx_ff, clr_idx_in;
   logic           clearing_ff, clearing_in;
   logic           mem_we;
   logic [VIW-1:0] mem_waddr;
   logic [DW-1:0]  mem_wdata;

   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + VIW'(1);
         if (clr_idx_ff == VIW'(NUM_VARS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clearing_ff <= clearing_in;
      end
   end

   // sweep owns the write port until every entry holds "all locks, no write"
   assign mem_we    = clearing_ff | wr_en;
   assign mem_waddr = clearing_ff ? clr_idx_ff : VIW'(wr_addr);
   assign mem_wdata = clearing_ff ? {{NUM_LOCKS{1'b1}}, INSTR_W'(0)} : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[VIW'(rd_addr)];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

// ----- rtl/core/lockset_race_detector_core.sv -----
// Lockset race detector: top level controller for trace requests.
// Depends on lrd_pkg, lrd_thread_table and lrd_var_mem.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   Create, acquire and release update the thread locksets in that cycle;
//   busy stays low and the next request may follow at once.
//   A read or write of a shared variable (not stack, in range) reads the
//   variable RAM at the accept edge, checks in the following cycle and, for a
//   write, writes back at its end, so busy is high for one cycle, since the
//   variable RAM read is registered ahead of the check.
//   A race, when found, appears on the rsp_ ports for exactly one cycle with
//   rsp_valid high; the accept edge loads lookup_ff, and the check in that
//   lookup cycle loads the rsp_ registers. The receiver cannot stall; the
//   response is taken at the edge that ends the rsp_valid cycle.
//   Requests that fall out of range or carry an unknown op do nothing.
//   After reset, busy stays high while the variable RAM is swept to
//   "every lock held, no write seen"; thread locksets clear at once.
module lockset_race_detector_core #(
   parameter int NUM_THREADS = 16,
   parameter int NUM_LOCKS   = 32,
   parameter int NUM_VARS    = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lrd_pkg::OP_W-1:0]      req_op,
   input  logic [lrd_pkg::THREAD_W-1:0]  req_thread_id,
   input  logic [lrd_pkg::THREAD_W-1:0]  req_child_thread,
   input  logic [lrd_pkg::LOCK_W-1:0]    req_lock_id,
   input  logic [lrd_pkg::VAR_W-1:0]     req_var_id,
   input  logic                          req_is_stack,
   input  logic [lrd_pkg::INSTR_W-1:0]   req_instr_id,
   output logic                          rsp_valid,
   output logic                          rsp_race_kind,
   output logic [lrd_pkg::INSTR_W-1:0]   rsp_first_instr,
   output logic [lrd_pkg::INSTR_W-1:0]   rsp_second_instr,
   output logic [lrd_pkg::VAR_W-1:0]     rsp_race_var
);
   import lrd_pkg::*;

   localparam int DW = NUM_LOCKS + INSTR_W;

   thr_cmd_type          thr_cmd;
   logic [NUM_LOCKS-1:0] held;
   logic                 clearing;
   logic                 accept;
   logic                 thread_ok, child_ok, lock_ok, var_ok;
   logic                 access;

   logic                 lookup_ff, lookup_in;
   logic                 is_write_ff;
   logic [NUM_LOCKS-1:0] held_ff;
   logic [INSTR_W-1:0]   instr_ff;
   logic [VAR_W-1:0]     var_ff;

   logic [DW-1:0]        rd_data;
   logic [NUM_LOCKS-1:0] old_locks;
   logic [INSTR_W-1:0]   old_instr;
   logic [NUM_LOCKS-1:0] new_locks;
   logic                 mem_wr_en;
   logic [DW-1:0]        mem_wr_data;

   logic                 race;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff;
   logic [INSTR_W-1:0]   rsp_first_ff;
   logic [INSTR_W-1:0]   rsp_second_ff;
   logic [VAR_W-1:0]     rsp_var_ff;

   assign busy   = clearing | lookup_ff;
   assign accept = start & ~busy;

   assign thread_ok = 32'(req_thread_id) < NUM_THREADS;
   assign child_ok  = 32'(req_child_thread) < NUM_THREADS;
   assign lock_ok   = 32'(req_lock_id) < NUM_LOCKS;
   assign var_ok    = 32'(req_var_id) < NUM_VARS;

   always_comb begin
      thr_cmd.create  = accept & thread_ok & child_ok & (req_op == OP_CREATE);
      thr_cmd.acquire = accept & thread_ok & lock_ok & (req_op == OP_ACQUIRE);
      thr_cmd.unlock  = accept & thread_ok & lock_ok & (req_op == OP_RELEASE);
      thr_cmd.thread  = req_thread_id;
      thr_cmd.child   = req_child_thread;
      thr_cmd.lock    = req_lock_id;
   end

   assign access = accept & thread_ok & var_ok & ~req_is_stack
                 & ((req_op == OP_READ) | (req_op == OP_WRITE));

   lrd_thread_table #(
      .NUM_THREADS (NUM_THREADS),
      .NUM_LOCKS   (NUM_LOCKS)
   ) u_thread_table (
      .clock (clock),
      .reset (reset),
      .cmd   (thr_cmd),
      .held  (held)
   );

   lrd_var_mem #(
      .NUM_VARS  (NUM_VARS),
      .NUM_LOCKS (NUM_LOCKS)
   ) u_var_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (access),
      .rd_addr  (req_var_id),
      .rd_data  (rd_data),
      .wr_en    (mem_wr_en),
      .wr_addr  (var_ff),
      .wr_data  (mem_wr_data),
      .clearing (clearing)
   );

   assign lookup_in = access;

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_ff <= 1'b0;
      end else begin
         lookup_ff <= lookup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (access) begin
         is_write_ff <= (req_op == OP_WRITE);
         held_ff     <= held;
         instr_ff    <= req_instr_id;
         var_ff      <= req_var_id;
      end
   end

   assign old_locks   = rd_data[DW-1:INSTR_W];
   assign old_instr   = rd_data[INSTR_W-1:0];
   assign new_locks   = old_locks & held_ff;
   assign mem_wr_en   = lookup_ff & is_write_ff;
   assign mem_wr_data = {new_locks, instr_ff};

   // read and write both race when the narrowed lockset comes out empty
   assign race         = lookup_ff & (new_locks == '0);
   assign rsp_valid_in = race;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (race) begin
         rsp_kind_ff   <= is_write_ff ? RACE_WW : RACE_WR;
         rsp_first_ff  <= old_instr;
         rsp_second_ff <= instr_ff;
         rsp_var_ff    <= var_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_race_kind    = rsp_kind_ff;
   assign rsp_first_instr  = rsp_first_ff;
   assign rsp_second_instr = rsp_second_ff;
   assign rsp_race_var     = rsp_var_ff;

`ifndef NO_ASSERTIONS
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(lookup_ff))
      else $error("response without a preceding variable lookup");

   a_ww_wrote_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_race_kind == RACE_WW) |-> $past(mem_wr_en))
      else $error("write-write race without write-back");

   a_lookup_one_cycle: assert property (@(posedge clock) disable iff (reset)
      lookup_ff |=> !lookup_ff)
      else $error("lookup lasted more than one cycle");

   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !access && !mem_wr_en)
      else $error("variable access during RAM sweep");
`endif

endmodule

// ----- sim/lrd_race_checker.sv -----
`timescale 1ns / 1ps
// Race checker for the lockset race detector: keeps its own thread and variable locksets,
// predicts the race of every accepted request and compares the reported races in order.
// Depends on lrd_pkg.
module lrd_race_checker #(
   parameter int NUM_THREADS = 16,
   parameter int NUM_LOCKS   = 32,
   parameter int NUM_VARS    = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [lrd_pkg::OP_W-1:0]     req_op,
   input  logic [lrd_pkg::THREAD_W-1:0] req_thread_id,
   input  logic [lrd_pkg::THREAD_W-1:0] req_child_thread,
   input  logic [lrd_pkg::LOCK_W-1:0]   req_lock_id,
   input  logic [lrd_pkg::VAR_W-1:0]    req_var_id,
   input  logic                         req_is_stack,
   input  logic [lrd_pkg::INSTR_W-1:0]  req_instr_id,
   input  logic                         rsp_valid,
   input  logic                         rsp_race_kind,
   input  logic [lrd_pkg::INSTR_W-1:0]  rsp_first_instr,
   input  logic [lrd_pkg::INSTR_W-1:0]  rsp_second_instr,
   input  logic [lrd_pkg::VAR_W-1:0]    rsp_race_var,
   output int                           fail_count,
   output int                           pending
);
   import lrd_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [INSTR_W-1:0] first;
      logic [INSTR_W-1:0] second;
      logic [VAR_W-1:0]   var_idx;
   } race_type;

   logic [NUM_LOCKS-1:0] held_locks      [NUM_THREADS];
   logic [NUM_LOCKS-1:0] var_write_locks [NUM_VARS];
   logic [INSTR_W-1:0]   var_last_write  [NUM_VARS];
   race_type             expected_races  [$];
   int                   errors;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   // Applies one request to the locksets; returns 1 when the request races.
   function automatic bit track_request(
      input  logic [OP_W-1:0]     op,
      input  logic [THREAD_W-1:0] thread,
      input  logic [THREAD_W-1:0] child,
      input  logic [LOCK_W-1:0]   lock,
      input  logic [VAR_W-1:0]    var_idx,
      input  logic                stack,
      input  logic [INSTR_W-1:0]  instr,
      output race_type            race
   );
      logic [NUM_LOCKS-1:0] held;
      bit                   found;
      found = 1'b0;
      race  = '0;
      if (thread < NUM_THREADS) begin
         if (op == OP_CREATE) begin
            if (child < NUM_THREADS)
               held_locks[child] = held_locks[thread];
         end else if (op == OP_ACQUIRE) begin
            if (lock < NUM_LOCKS)
               held_locks[thread][lock] = 1'b1;
         end else if (op == OP_RELEASE) begin
            if (lock < NUM_LOCKS)
               held_locks[thread][lock] = 1'b0;
         end else if ((op == OP_READ || op == OP_WRITE) && !stack && var_idx < NUM_VARS) begin
            held = held_locks[thread];
            if (op == OP_READ) begin
               if ((held & var_write_locks[var_idx]) == '0) begin
                  race  = '{RACE_WR, var_last_write[var_idx], instr, var_idx};
                  found = 1'b1;
               end
            end else begin
               var_write_locks[var_idx] &= held;
               if (var_write_locks[var_idx] == '0) begin
                  race  = '{RACE_WW, var_last_write[var_idx], instr, var_idx};
                  found = 1'b1;
               end
               var_last_write[var_idx] = instr;
            end
         end
      end
      return found;
   endfunction

   always @(posedge clock) begin
      race_type want;
      race_type predicted;
      if (reset) begin
         for (int i = 0; i < NUM_THREADS; i++)
            held_locks[i] = '0;
         for (int i = 0; i < NUM_VARS; i++) begin
            var_write_locks[i] = '1;
            var_last_write[i]  = '0;
         end
         expected_races.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_races.size() == 0) begin
               report_mismatch($sformatf("race on var %0d with none expected", rsp_race_var));
            end else begin
               want = expected_races.pop_front();
               if (rsp_race_kind !== want.kind)
                  report_mismatch($sformatf("race_kind %b, expected %b",
                                            rsp_race_kind, want.kind));
               if (rsp_first_instr !== want.first)
                  report_mismatch($sformatf("first_instr %h, expected %h",
                                            rsp_first_instr, want.first));
               if (rsp_second_instr !== want.second)
                  report_mismatch($sformatf("second_instr %h, expected %h",
                                            rsp_second_instr, want.second));
               if (rsp_race_var !== want.var_idx)
                  report_mismatch($sformatf("race_var %0d, expected %0d",
                                            rsp_race_var, want.var_idx));
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid unknown");
         end
         if (start === 1'b1 && busy === 1'b0) begin
            if (track_request(req_op, req_thread_id, req_child_thread, req_lock_id,
                              req_var_id, req_is_stack, req_instr_id, predicted))
               expected_races = {expected_races, predicted};
         end
      end
      pending    <= expected_races.size();
      fail_count <= errors;
   end

endmodule

// ----- sim/lockset_race_detector_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for lockset_race_detector_core: directed and random trace requests,
// verdict and watchdog. Depends on lrd_pkg, the core RTL and lrd_race_checker.
module lockset_race_detector_core_tb;
   import lrd_pkg::*;

   localparam int NUM_THREADS     = 16;
   localparam int NUM_LOCKS       = 32;
   localparam int NUM_VARS        = 1024;
   localparam int WINDOW          = 8;
   localparam int ITEMS_PER_PHASE = 385;
   localparam int STALL_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 8;

   localparam logic [THREAD_W-1:0] LAST_THREAD = THREAD_W'(NUM_THREADS - 1);
   localparam logic [LOCK_W-1:0]   LAST_LOCK   = LOCK_W'(NUM_LOCKS - 1);
   localparam logic [VAR_W-1:0]    LAST_VAR    = VAR_W'(NUM_VARS - 1);

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [THREAD_W-1:0] req_thread_id;
   logic [THREAD_W-1:0] req_child_thread;
   logic [LOCK_W-1:0]   req_lock_id;
   logic [VAR_W-1:0]    req_var_id;
   logic                req_is_stack;
   logic [INSTR_W-1:0]  req_instr_id;
   logic                rsp_valid;
   logic                rsp_race_kind;
   logic [INSTR_W-1:0]  rsp_first_instr;
   logic [INSTR_W-1:0]  rsp_second_instr;
   logic [VAR_W-1:0]    rsp_race_var;

   int               fail_count;
   int               pending;
   int               idle_pct;
   int               sent;
   int               stall_cycles;
   logic [VAR_W-1:0] window_base;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   lockset_race_detector_core #(
      .NUM_THREADS (NUM_THREADS),
      .NUM_LOCKS   (NUM_LOCKS),
      .NUM_VARS    (NUM_VARS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_thread_id    (req_thread_id),
      .req_child_thread (req_child_thread),
      .req_lock_id      (req_lock_id),
      .req_var_id       (req_var_id),
      .req_is_stack     (req_is_stack),
      .req_instr_id     (req_instr_id),
      .rsp_valid        (rsp_valid),
      .rsp_race_kind    (rsp_race_kind),
      .rsp_first_instr  (rsp_first_instr),
      .rsp_second_instr (rsp_second_instr),
      .rsp_race_var     (rsp_race_var)
   );

   lrd_race_checker #(
      .NUM_THREADS (NUM_THREADS),
      .NUM_LOCKS   (NUM_LOCKS),
      .NUM_VARS    (NUM_VARS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_thread_id    (req_thread_id),
      .req_child_thread (req_child_thread),
      .req_lock_id      (req_lock_id),
      .req_var_id       (req_var_id),
      .req_is_stack     (req_is_stack),
      .req_instr_id     (req_instr_id),
      .rsp_valid        (rsp_valid),
      .rsp_race_kind    (rsp_race_kind),
      .rsp_first_instr  (rsp_first_instr),
      .rsp_second_instr (rsp_second_instr),
      .rsp_race_var     (rsp_race_var),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // Counts cycles with neither a request taken nor a race reported.
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL lockset_race_detector_core");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Holds start high until the request is taken; start stays high for a following request.
   task automatic send(
      input logic [OP_W-1:0]     op,
      input logic [THREAD_W-1:0] thread,
      input logic [THREAD_W-1:0] child,
      input logic [LOCK_W-1:0]   lock,
      input logic [VAR_W-1:0]    var_idx,
      input logic                stack,
      input logic [INSTR_W-1:0]  instr
   );
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_op           <= op;
      req_thread_id    <= thread;
      req_child_thread <= child;
      req_lock_id      <= lock;
      req_var_id       <= var_idx;
      req_is_stack     <= stack;
      req_instr_id     <= instr;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      sent++;
   endtask

   task automatic lock_op(input logic [OP_W-1:0] op, input logic [THREAD_W-1:0] thread,
                          input logic [LOCK_W-1:0] lock);
      send(op, thread, THREAD_W'($urandom), lock, VAR_W'($urandom), 1'($urandom), $urandom);
   endtask

   task automatic access(input logic [OP_W-1:0] op, input logic [THREAD_W-1:0] thread,
                         input logic [VAR_W-1:0] var_idx, input logic [INSTR_W-1:0] instr);
      send(op, thread, THREAD_W'($urandom), LOCK_W'($urandom), var_idx, 1'b0, instr);
   endtask

   // Critical section on the current variable window, guarded by one lock;
   // some sections skip the acquire, and some of those also skip the release.
   task automatic guarded_section;
      logic [THREAD_W-1:0] thread;
      logic [LOCK_W-1:0]   guard;
      bit                  broken;
      thread = THREAD_W'($urandom);
      if ($urandom_range(14) == 0)
         window_base = VAR_W'($urandom_range(NUM_VARS - WINDOW));
      guard  = window_base[LOCK_W-1:0];
      broken = $urandom_range(9) < 2;
      if (!broken)
         lock_op(OP_ACQUIRE, thread, guard);
      repeat ($urandom_range(1, 4))
         access($urandom_range(1) ? OP_WRITE : OP_READ, thread,
                VAR_W'(window_base + $urandom_range(WINDOW - 1)), $urandom);
      if (!broken || $urandom_range(1))
         lock_op(OP_RELEASE, thread, guard);
   endtask

   task automatic noise_request;
      logic [OP_W-1:0]  op;
      logic [VAR_W-1:0] var_idx;
      if ($urandom_range(99) < 5)
         op = OP_W'($urandom_range(OP_WRITE + 1, 2**OP_W - 1));
      else
         op = OP_W'($urandom_range(OP_CREATE, OP_WRITE));
      if ($urandom_range(9) < 7)
         var_idx = VAR_W'(window_base + $urandom_range(WINDOW - 1));
      else
         var_idx = VAR_W'($urandom);
      send(op, THREAD_W'($urandom), THREAD_W'($urandom), LOCK_W'($urandom), var_idx,
           $urandom_range(9) == 0, $urandom);
   endtask

   task automatic run_phase(input int pct);
      int target;
      idle_pct = pct;
      target   = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
         if ($urandom_range(9) < 6)
            guarded_section();
         else
            noise_request();
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_CREATE;
      req_thread_id    = '0;
      req_child_thread = '0;
      req_lock_id      = '0;
      req_var_id       = '0;
      req_is_stack     = 1'b0;
      req_instr_id     = '0;
      idle_pct         = 0;
      sent             = 0;
      window_base      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // read before any write with no lock held
      access(OP_READ, 4'd0, 10'd0, 32'h0000_0001);
      lock_op(OP_ACQUIRE, 4'd0, LAST_LOCK);
      lock_op(OP_ACQUIRE, 4'd0, 5'd0);
      access(OP_READ, 4'd0, 10'd1, 32'h0000_0002);
      access(OP_WRITE, 4'd0, LAST_VAR, 32'hFFFF_FFFF);
      // child inherits the parent's lockset
      send(OP_CREATE, 4'd0, LAST_THREAD, '0, '0, 1'b0, '0);
      access(OP_WRITE, LAST_THREAD, LAST_VAR, 32'h0000_0000);
      lock_op(OP_RELEASE, LAST_THREAD, 5'd0);
      lock_op(OP_RELEASE, LAST_THREAD, 5'd5);
      access(OP_WRITE, LAST_THREAD, LAST_VAR, 32'h5A5A_A5A5);
      // unlocked write then read: write-write, then write-read race
      access(OP_WRITE, 4'd1, LAST_VAR, 32'h1234_5678);
      access(OP_READ, 4'd1, LAST_VAR, 32'h8765_4321);
      send(OP_CREATE, 4'd3, 4'd3, '1, '1, 1'b1, '1);
      for (int k = OP_WRITE + 1; k < 2**OP_W; k++)
         send(OP_W'(k), THREAD_W'($urandom), THREAD_W'($urandom), LOCK_W'($urandom),
              LAST_VAR, 1'b0, $urandom);
      send(OP_READ, 4'd1, '0, '0, LAST_VAR, 1'b1, 32'hAAAA_5555);
      send(OP_WRITE, 4'd1, '0, '0, LAST_VAR, 1'b1, 32'h5555_AAAA);
      lock_op(OP_ACQUIRE, LAST_THREAD, 5'd16);
      access(OP_READ, LAST_THREAD, 10'd512, 32'h0000_FFFF);
      access(OP_WRITE, LAST_THREAD, 10'd512, 32'hFFFF_0000);
      access(OP_READ, 4'd2, 10'd512, 32'h0F0F_0F0F);

      run_phase(9);
      run_phase(84);
      run_phase(0);
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS lockset_race_detector_core");
      else
         $display("FAIL lockset_race_detector_core");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/lrd_pkg.sv
rtl/core/lrd_thread_table.sv
rtl/core/lrd_var_mem.sv
rtl/core/lockset_race_detector_core.sv
sim/lrd_race_checker.sv
sim/lockset_race_detector_core_tb.sv
